[hdl/six_axis_admittance_integrator_unit_defines.svh]
// assertion macros used by the checker file
`ifndef SIX_AXIS_ADMITTANCE_INTEGRATOR_UNIT_DEFINES_SVH
`define SIX_AXIS_ADMITTANCE_INTEGRATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SAAI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SAAI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/saai_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package saai_pkg;

  localparam int unsigned AxesMax  = 6;
  localparam int unsigned ForceW   = 16;
  localparam int unsigned OffsetW  = 48;
  localparam int unsigned GainW    = 10;
  localparam int unsigned StepW    = 16;
  localparam int unsigned LimitW   = 31;
  localparam int unsigned TableW   = AxesMax * GainW;
  localparam int unsigned VelW     = 32;
  localparam int unsigned PosW     = 34;
  localparam int unsigned AccW     = 32;
  localparam int unsigned SumW     = 42;
  localparam int unsigned MulAW    = 42;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned ProdW    = 52;
  localparam int unsigned InDataW  = AxesMax * ForceW;
  localparam int unsigned OutDataW = AxesMax * OffsetW;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned RegIdxW  = 3;

  localparam logic signed [ProdW-1:0] PosBound = 52'sd6553600000;
  localparam logic signed [ProdW-1:0] SumBound = 52'sd1099511627776;

  localparam logic [TableW-1:0] RecipMassRst = {AxesMax{10'd256}};
  localparam logic [TableW-1:0] GainRst      = {AxesMax{10'd80}};
  localparam logic [StepW-1:0]  TimeStepRst  = 16'd2621;
  localparam logic [LimitW-1:0] AccLimitRst  = 31'd16384;
  localparam logic [LimitW-1:0] VelLimitRst  = 31'd22938;
  localparam logic [AxesMax-1:0] AxisEnRst   = '1;

  typedef enum logic [RegIdxW-1:0] {
    REG_RECIP_MASS = 3'd0,
    REG_DAMPING    = 3'd1,
    REG_STIFFNESS  = 3'd2,
    REG_TIME_STEP  = 3'd3,
    REG_ACC_LIMIT  = 3'd4,
    REG_VEL_LIMIT  = 3'd5,
    REG_AXIS_EN    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [TableW-1:0]  recip_mass;
    logic [TableW-1:0]  damping;
    logic [TableW-1:0]  stiffness;
    logic [StepW-1:0]   time_step;
    logic [LimitW-1:0]  accel_limit;
    logic [LimitW-1:0]  velocity_limit;
    logic [AxesMax-1:0] axis_enable;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAMP,
    ST_STIFF,
    ST_SUM,
    ST_MASS,
    ST_ACC,
    ST_VMUL,
    ST_VEL,
    ST_PMUL,
    ST_POS,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_DAMP,
    MUL_STIFF,
    MUL_MASS,
    MUL_ACC,
    MUL_VEL
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sum_part;
    logic     sum_fin;
    logic     acc_fin;
    logic     vel_fin;
    logic     pos_fin;
    logic     zero_axis;
    logic     next_axis;
    logic     publish;
  } dp_cmd_t;

  typedef struct packed {
    logic axis_en;
    logic last_axis;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [ProdW-1:0] clamp_sym(
    input logic signed [ProdW-1:0] x,
    input logic signed [ProdW-1:0] lim
  );
    logic signed [ProdW-1:0] r;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/saai_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module saai_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [saai_pkg::CfgAddrW-1:0]  paddr_i,
  input  wire logic [saai_pkg::CfgDataW-1:0]  pwdata_i,
  output logic      [saai_pkg::CfgDataW-1:0]  prdata_o,
  output saai_pkg::cfg_t                      cfg_o
);

  saai_pkg::cfg_t     cfg_q, cfg_d;
  saai_pkg::reg_idx_e idx;
  logic               wr_en;

  // 64-bit registers on an 8-byte stride
  assign idx   = saai_pkg::reg_idx_e'(paddr_i[saai_pkg::CfgAddrW-1:3]);
  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        saai_pkg::REG_RECIP_MASS: cfg_d.recip_mass = pwdata_i[saai_pkg::TableW-1:0];
        saai_pkg::REG_DAMPING:    cfg_d.damping = pwdata_i[saai_pkg::TableW-1:0];
        saai_pkg::REG_STIFFNESS:  cfg_d.stiffness = pwdata_i[saai_pkg::TableW-1:0];
        saai_pkg::REG_TIME_STEP:  cfg_d.time_step = pwdata_i[saai_pkg::StepW-1:0];
        saai_pkg::REG_ACC_LIMIT:  cfg_d.accel_limit = pwdata_i[saai_pkg::LimitW-1:0];
        saai_pkg::REG_VEL_LIMIT:  cfg_d.velocity_limit = pwdata_i[saai_pkg::LimitW-1:0];
        saai_pkg::REG_AXIS_EN:    cfg_d.axis_enable = pwdata_i[saai_pkg::AxesMax-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recip_mass     <= saai_pkg::RecipMassRst;
      cfg_q.damping        <= saai_pkg::GainRst;
      cfg_q.stiffness      <= saai_pkg::GainRst;
      cfg_q.time_step      <= saai_pkg::TimeStepRst;
      cfg_q.accel_limit    <= saai_pkg::AccLimitRst;
      cfg_q.velocity_limit <= saai_pkg::VelLimitRst;
      cfg_q.axis_enable    <= saai_pkg::AxisEnRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      saai_pkg::REG_RECIP_MASS: prdata_o = saai_pkg::CfgDataW'(cfg_q.recip_mass);
      saai_pkg::REG_DAMPING:    prdata_o = saai_pkg::CfgDataW'(cfg_q.damping);
      saai_pkg::REG_STIFFNESS:  prdata_o = saai_pkg::CfgDataW'(cfg_q.stiffness);
      saai_pkg::REG_TIME_STEP:  prdata_o = saai_pkg::CfgDataW'(cfg_q.time_step);
      saai_pkg::REG_ACC_LIMIT:  prdata_o = saai_pkg::CfgDataW'(cfg_q.accel_limit);
      saai_pkg::REG_VEL_LIMIT:  prdata_o = saai_pkg::CfgDataW'(cfg_q.velocity_limit);
      saai_pkg::REG_AXIS_EN:    prdata_o = saai_pkg::CfgDataW'(cfg_q.axis_enable);
      default:                  prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/saai_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module saai_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_tvalid_i,
  output logic                      in_tready_o,
  input  wire saai_pkg::dp_status_t status_i,
  output saai_pkg::dp_cmd_t         cmd_o
);

  saai_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= saai_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      saai_pkg::ST_IDLE: begin
        if (in_tvalid_i) state_d = saai_pkg::ST_DAMP;
      end
      saai_pkg::ST_DAMP: begin
        if (status_i.axis_en) begin
          state_d = saai_pkg::ST_STIFF;
        end else if (status_i.last_axis) begin
          state_d = saai_pkg::ST_DONE;
        end
      end
      saai_pkg::ST_STIFF: state_d = saai_pkg::ST_SUM;
      saai_pkg::ST_SUM:   state_d = saai_pkg::ST_MASS;
      saai_pkg::ST_MASS:  state_d = saai_pkg::ST_ACC;
      saai_pkg::ST_ACC:   state_d = saai_pkg::ST_VMUL;
      saai_pkg::ST_VMUL:  state_d = saai_pkg::ST_VEL;
      saai_pkg::ST_VEL:   state_d = saai_pkg::ST_PMUL;
      saai_pkg::ST_PMUL:  state_d = saai_pkg::ST_POS;
      saai_pkg::ST_POS: begin
        state_d = status_i.last_axis ? saai_pkg::ST_DONE : saai_pkg::ST_DAMP;
      end
      saai_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = saai_pkg::ST_IDLE;
      end
      default: state_d = saai_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = saai_pkg::MUL_DAMP;
    in_tready_o   = 1'b0;
    case (state_q)
      saai_pkg::ST_IDLE: begin
        in_tready_o   = 1'b1;
        cmd_o.load_in = in_tvalid_i;
      end
      saai_pkg::ST_DAMP: begin
        if (status_i.axis_en) begin
          cmd_o.mul_en = 1'b1;
        end else begin
          cmd_o.zero_axis = 1'b1;
          cmd_o.next_axis = 1'b1;
        end
      end
      saai_pkg::ST_STIFF: begin
        cmd_o.sum_part = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = saai_pkg::MUL_STIFF;
      end
      saai_pkg::ST_SUM: cmd_o.sum_fin = 1'b1;
      saai_pkg::ST_MASS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = saai_pkg::MUL_MASS;
      end
      saai_pkg::ST_ACC: cmd_o.acc_fin = 1'b1;
      saai_pkg::ST_VMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = saai_pkg::MUL_ACC;
      end
      saai_pkg::ST_VEL: cmd_o.vel_fin = 1'b1;
      saai_pkg::ST_PMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = saai_pkg::MUL_VEL;
      end
      saai_pkg::ST_POS: begin
        cmd_o.pos_fin   = 1'b1;
        cmd_o.next_axis = 1'b1;
      end
      saai_pkg::ST_DONE: cmd_o.publish = status_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/saai_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module saai_datapath #(
  parameter int unsigned AXIS_COUNT = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire saai_pkg::dp_cmd_t             cmd_i,
  output saai_pkg::dp_status_t               status_o,
  input  wire saai_pkg::cfg_t                cfg_i,
  input  wire logic [saai_pkg::InDataW-1:0]  in_tdata_i,
  output logic      [saai_pkg::OutDataW-1:0] out_tdata_o,
  output logic                               out_tuser_o,
  output logic                               out_tvalid_o,
  input  wire logic                          out_tready_i
);

  localparam int unsigned AxisIdxW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam logic [AxisIdxW-1:0] LastAxis = AxisIdxW'(AXIS_COUNT - 1);
  localparam int unsigned PW = saai_pkg::ProdW;

  // per-axis state
  logic signed [saai_pkg::ForceW-1:0] force_q [AXIS_COUNT];
  logic signed [saai_pkg::VelW-1:0]   vel_q   [AXIS_COUNT];
  logic signed [saai_pkg::PosW-1:0]   pos_q   [AXIS_COUNT];
  logic signed [saai_pkg::PosW-1:0]   out_pos_q [AXIS_COUNT];
  logic [AxisIdxW-1:0] axis_q;
  logic                ovf_q;
  logic                out_ovf_q;
  logic                out_valid_q;

  // working registers
  logic signed [PW-1:0]              prod_q;
  logic signed [saai_pkg::SumW-1:0]  part_q, sum_q;
  logic signed [saai_pkg::AccW-1:0]  acc_q;
  logic signed [saai_pkg::VelW-1:0]  vnew_q;

  logic signed [saai_pkg::ForceW-1:0] f_cur;
  logic signed [saai_pkg::VelW-1:0]   v_cur;
  logic signed [saai_pkg::PosW-1:0]   p_cur;
  logic [saai_pkg::GainW-1:0]         d_gain, k_gain, m_gain;

  logic signed [saai_pkg::MulAW-1:0]               mul_a;
  logic signed [saai_pkg::MulBW-1:0]               mul_b;
  logic signed [saai_pkg::MulAW+saai_pkg::MulBW-1:0] mul_full;

  logic signed [PW-1:0] part_d, sum_d, acc_d, vel_d, psum, pos_d;
  logic signed [PW-1:0] alim, vlim;
  logic                 pos_ovf;

  assign f_cur  = force_q[axis_q];
  assign v_cur  = vel_q[axis_q];
  assign p_cur  = pos_q[axis_q];
  assign d_gain = cfg_i.damping[saai_pkg::GainW*axis_q +: saai_pkg::GainW];
  assign k_gain = cfg_i.stiffness[saai_pkg::GainW*axis_q +: saai_pkg::GainW];
  assign m_gain = cfg_i.recip_mass[saai_pkg::GainW*axis_q +: saai_pkg::GainW];
  assign alim   = PW'(cfg_i.accel_limit);
  assign vlim   = PW'(cfg_i.velocity_limit);

  // shared multiplier, signed operand by unsigned gain or step
  always_comb begin
    case (cmd_i.mul_sel)
      saai_pkg::MUL_DAMP: begin
        mul_a = saai_pkg::MulAW'(v_cur);
        mul_b = saai_pkg::MulBW'(d_gain);
      end
      saai_pkg::MUL_STIFF: begin
        mul_a = saai_pkg::MulAW'(p_cur);
        mul_b = saai_pkg::MulBW'(k_gain);
      end
      saai_pkg::MUL_MASS: begin
        mul_a = saai_pkg::MulAW'(sum_q);
        mul_b = saai_pkg::MulBW'(m_gain);
      end
      saai_pkg::MUL_ACC: begin
        mul_a = saai_pkg::MulAW'(acc_q);
        mul_b = saai_pkg::MulBW'(cfg_i.time_step);
      end
      saai_pkg::MUL_VEL: begin
        mul_a = saai_pkg::MulAW'(vnew_q);
        mul_b = saai_pkg::MulBW'(cfg_i.time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // post-multiply arithmetic, one step per state
  always_comb begin
    part_d  = (PW'(f_cur) <<< 8) - (prod_q >>> 4);
    sum_d   = saai_pkg::clamp_sym(PW'(part_q) - (prod_q >>> 4), saai_pkg::SumBound);
    acc_d   = saai_pkg::clamp_sym(prod_q >>> 8, alim);
    vel_d   = saai_pkg::clamp_sym(PW'(v_cur) + (prod_q >>> 16), vlim);
    psum    = PW'(p_cur) + (prod_q >>> 16);
    pos_ovf = (psum > saai_pkg::PosBound) || (psum < -saai_pkg::PosBound);
    pos_d   = saai_pkg::clamp_sym(psum, saai_pkg::PosBound);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        force_q[i] <= in_tdata_i[saai_pkg::ForceW*i +: saai_pkg::ForceW];
      end
    end
    if (cmd_i.mul_en)   prod_q <= PW'(mul_full);
    if (cmd_i.sum_part) part_q <= saai_pkg::SumW'(part_d);
    if (cmd_i.sum_fin)  sum_q  <= saai_pkg::SumW'(sum_d);
    if (cmd_i.acc_fin)  acc_q  <= saai_pkg::AccW'(acc_d);
    if (cmd_i.vel_fin)  vnew_q <= saai_pkg::VelW'(vel_d);
    if (cmd_i.publish) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        out_pos_q[i] <= pos_q[i];
      end
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= '0;
      end
      axis_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        axis_q <= '0;
        ovf_q  <= 1'b0;
      end else if (cmd_i.next_axis) begin
        axis_q <= AxisIdxW'(axis_q + 1'b1);
      end
      if (cmd_i.zero_axis) begin
        pos_q[axis_q] <= '0;
      end
      if (cmd_i.pos_fin) begin
        pos_q[axis_q] <= saai_pkg::PosW'(pos_d);
        vel_q[axis_q] <= vnew_q;
        ovf_q         <= ovf_q | pos_ovf;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.axis_en   = cfg_i.axis_enable[axis_q];
  assign status_o.last_axis = (axis_q == LastAxis);
  assign status_o.out_free  = !out_valid_q || out_tready_i;

  for (genvar g = 0; g < saai_pkg::AxesMax; g++) begin : g_out
    if (g < AXIS_COUNT) begin : g_live
      assign out_tdata_o[saai_pkg::OffsetW*g +: saai_pkg::OffsetW] =
        saai_pkg::OffsetW'(out_pos_q[g]);
    end else begin : g_idle
      assign out_tdata_o[saai_pkg::OffsetW*g +: saai_pkg::OffsetW] = '0;
    end
  end

  assign out_tuser_o  = out_ovf_q;
  assign out_tvalid_o = out_valid_q;

endmodule

`default_nettype wire

[hdl/six_axis_admittance_integrator_unit.sv]
// Six-axis admittance integrator. Each transfer on the slave stream carries
// one Q8.8 force or torque sample per axis; for every enabled axis the block
// runs one step of a mass-spring-damper admittance law (acceleration from
// force minus damping and stiffness terms, scaled by reciprocal mass and
// clamped, then Euler updates of velocity and position with clamping) and
// returns one transfer on the master stream with the six Q31.16 positions
// and a flag set when any position hit the +/-100000.0 bound. The user must
// set gains, time step, limits and the axis enable mask over the APB port
// while the block is idle, which the block does not enforce. One multiplier
// is shared over all arithmetic: an enabled axis steps through the DAMP,
// STIFF, SUM, MASS, ACC, VMUL, VEL, PMUL and POS states, a disabled one only
// DAMP. A finished result sits in an output register, so the next item is
// taken while the previous result still waits on the master side.
`timescale 1ns / 1ps
`default_nettype none

module six_axis_admittance_integrator_unit #(
  parameter int unsigned AXIS_COUNT = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // force_x, force_y, force_z, torque_rx, torque_ry, torque_rz, 16 bits each
  input  wire logic [saai_pkg::InDataW-1:0]   s_axis_tdata,
  // master stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // offset_x, offset_y, offset_z, offset_rx, offset_ry, offset_rz, 48 bits each
  output logic      [saai_pkg::OutDataW-1:0]  m_axis_tdata,
  // overflow
  output logic      [0:0]                     m_axis_tuser,
  // register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [saai_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [saai_pkg::CfgDataW-1:0]  pwdata,
  output logic      [saai_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready
);

  saai_pkg::cfg_t       cfg;
  saai_pkg::dp_cmd_t    cmd;
  saai_pkg::dp_status_t status;

  // register transfers always complete in the access cycle
  assign pready = 1'b1;

  saai_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // sequencer: one state per multiply or post-multiply step
  saai_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // axis state, shared multiplier and output register
  saai_datapath #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_i        (cfg),
    .in_tdata_i   (s_axis_tdata),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser[0]),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready)
  );

endmodule

`default_nettype wire

[hdl/saai_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "six_axis_admittance_integrator_unit_defines.svh"

module saai_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [saai_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic [0:0]                    m_axis_tuser
);

  // items taken in but not yet delivered
  logic [1:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  `SAAI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `SAAI_ASSERT_NOW(a_out_has_item, clk_i, rst_ni, m_axis_tvalid, pending_q != 2'd0, "result with no item in flight")
  `SAAI_ASSERT_NOW(a_two_max, clk_i, rst_ni, pending_q == 2'd2, !s_axis_tready, "third item accepted")
  `SAAI_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer, !s_axis_tready, "ready held after input transfer")

endmodule

bind six_axis_admittance_integrator_unit saai_checker u_saai_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
